### src/abpw_pkg.sv
// Package for the alpha blend pixel writer: beat payload types, command and
// status codes, register indexes, controller/datapath handshake structs.
// No dependencies.
package abpw_pkg;

	localparam int unsigned MAX_WIDTH_DEF    = 2048;
	localparam int unsigned MAX_HEIGHT_DEF   = 1024;
	localparam int unsigned STORE_PIXELS_DEF = 2097152;

	typedef enum logic [1:0] {
		CMD_READ = 2'd0,
		CMD_DRAW = 2'd1,
		CMD_FILL = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
	localparam logic [1:0] ST_NO_MODE     = 2'd2;
	localparam logic [1:0] ST_BOUND       = 2'd3;

	localparam logic [1:0] REG_SUPPORTED = 2'd0;
	localparam logic [1:0] REG_MODE_SET  = 2'd1;
	localparam logic [1:0] REG_WIDTH     = 2'd2;
	localparam logic [1:0] REG_HEIGHT    = 2'd3;

	localparam int unsigned CFG_DW = 12;
	localparam int unsigned CFG_IW = 2;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
	localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

	typedef struct packed {
		logic [1:0]  command;
		logic [10:0] x;
		logic [9:0]  y;
		logic [11:0] rect_width;
		logic [10:0] rect_height;
		logic [7:0]  alpha;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} in_beat_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] read_alpha;
		logic [7:0] read_red;
		logic [7:0] read_green;
		logic [7:0] read_blue;
	} out_beat_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // take the input beat
		logic check;      // register config/fill bound status
		logic addr;       // compute word address and pixel bound
		logic mem_rd;     // read the addressed word
		logic mem_wr;     // blend/write or capture read data
		logic set_bound;  // pixel out of bound
		logic step_col;
		logic step_row;
		logic load_out;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pre_err;
		logic fill_empty;
		logic is_fill;
		logic pix_ok;
		logic col_last;
		logic row_last;
		logic out_free;
	} dp_stat_t;

endpackage

### src/abpw_dp.sv
// Datapath of the alpha blend pixel writer: config registers, frame store,
// address multiplier, blend arithmetic, fill counters and output register.
// Depends on abpw_pkg.
module abpw_dp #(
	parameter int unsigned MAX_WIDTH    = abpw_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT   = abpw_pkg::MAX_HEIGHT_DEF,
	parameter int unsigned STORE_PIXELS = abpw_pkg::STORE_PIXELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  abpw_pkg::in_beat_t           in_data,
	input  logic                         out_stall,
	output logic                         out_valid,
	output abpw_pkg::out_beat_t          out_data,
	input  logic                         cfg_we,
	input  logic [abpw_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [abpw_pkg::CFG_DW-1:0]  cfg_data,
	input  abpw_pkg::ctrl_cmd_t          cmd,
	output abpw_pkg::dp_stat_t           stat
);
	import abpw_pkg::*;

	localparam int unsigned AW = (STORE_PIXELS > 1) ? $clog2(STORE_PIXELS) : 1;

	// config
	logic        supported_q;
	logic        mode_set_q;
	logic [11:0] scr_w_q;
	logic [10:0] scr_h_q;

	// latched command
	logic [1:0]  cmd_q;
	logic [10:0] x_q;
	logic [9:0]  y_q;
	logic [11:0] w_q;
	logic [10:0] h_q;
	logic [7:0]  a_q, r_q, g_q, b_q;

	logic [12:0] i_q;
	logic [11:0] j_q;
	logic [1:0]  status_q;
	logic [24:0] addr_q;
	logic        pix_ok_q;
	logic [23:0] rdata_q;
	logic        read_ok_q;
	logic [23:0] rpix_q;
	out_beat_t   out_q;
	logic        out_valid_q;

	logic [23:0] mem [STORE_PIXELS];

	logic [12:0] x_end;
	logic [11:0] y_end;
	logic [1:0]  pre_status;
	logic [23:0] prod;
	logic [24:0] addr_c;
	logic        pix_ok_c;
	logic [15:0] mix_r, mix_g, mix_b;
	logic [7:0]  inv_a;
	logic [23:0] new_word;
	logic        is_read;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supported_q <= 1'b0;
			mode_set_q  <= 1'b0;
			scr_w_q     <= '0;
			scr_h_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SUPPORTED: supported_q <= cfg_data[0];
				REG_MODE_SET:  mode_set_q  <= cfg_data[0];
				REG_WIDTH:     scr_w_q     <= cfg_data[11:0];
				REG_HEIGHT:    scr_h_q     <= cfg_data[10:0];
				default:       ;
			endcase
		end
	end

	assign x_end   = 13'(x_q) + 13'(w_q);
	assign y_end   = 12'(y_q) + 12'(h_q);
	assign is_read = (cmd_q == CMD_READ);

	always_comb begin
		if (!supported_q || cmd_q == CMD_NONE)
			pre_status = ST_UNSUPPORTED;
		else if (!mode_set_q)
			pre_status = ST_NO_MODE;
		else if (cmd_q == CMD_FILL && (x_end > 13'(scr_w_q) || y_end > 12'(scr_h_q)))
			pre_status = ST_BOUND;
		else
			pre_status = ST_OK;
	end

	// stride * line + column
	assign prod     = scr_w_q * j_q;
	assign addr_c   = 25'(prod) + 25'(i_q);
	assign pix_ok_c = (i_q < 13'(scr_w_q)) && (j_q < 12'(scr_h_q))
		&& ({1'b0, i_q} < 14'(MAX_WIDTH)) && ({1'b0, j_q} < 13'(MAX_HEIGHT))
		&& (addr_c < 25'(STORE_PIXELS));

	assign inv_a = ALPHA_OPAQUE - a_q;
	assign mix_r = r_q * a_q + rdata_q[23:16] * inv_a;
	assign mix_g = g_q * a_q + rdata_q[15:8] * inv_a;
	assign mix_b = b_q * a_q + rdata_q[7:0] * inv_a;
	assign new_word = (a_q == ALPHA_OPAQUE) ? {r_q, g_q, b_q}
		: {mix_r[15:8], mix_g[15:8], mix_b[15:8]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q     <= in_data.command;
			x_q       <= in_data.x;
			y_q       <= in_data.y;
			w_q       <= in_data.rect_width;
			h_q       <= in_data.rect_height;
			a_q       <= in_data.alpha;
			r_q       <= in_data.red;
			g_q       <= in_data.green;
			b_q       <= in_data.blue;
			i_q       <= 13'(in_data.x);
			j_q       <= 12'(in_data.y);
			read_ok_q <= 1'b0;
		end
		if (cmd.check)
			status_q <= pre_status;
		if (cmd.set_bound)
			status_q <= ST_BOUND;
		if (cmd.addr) begin
			addr_q   <= addr_c;
			pix_ok_q <= pix_ok_c;
		end
		if (cmd.step_col)
			i_q <= i_q + 13'd1;
		if (cmd.step_row) begin
			i_q <= 13'(x_q);
			j_q <= j_q + 12'd1;
		end
		if (cmd.mem_wr && is_read) begin
			rpix_q    <= rdata_q;
			read_ok_q <= 1'b1;
		end
	end

	// frame store: one read or one write per cycle
	always_ff @(posedge clk) begin
		if (cmd.mem_rd)
			rdata_q <= mem[addr_q[AW-1:0]];
		if (cmd.mem_wr && !is_read && a_q != ALPHA_CLEAR)
			mem[addr_q[AW-1:0]] <= new_word;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.status     <= status_q;
			out_q.read_alpha <= read_ok_q ? ALPHA_OPAQUE : ALPHA_CLEAR;
			out_q.read_red   <= read_ok_q ? rpix_q[23:16] : 8'h00;
			out_q.read_green <= read_ok_q ? rpix_q[15:8] : 8'h00;
			out_q.read_blue  <= read_ok_q ? rpix_q[7:0] : 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.pre_err    = (pre_status != ST_OK);
	assign stat.fill_empty = (cmd_q == CMD_FILL) && (w_q == 12'd0 || h_q == 11'd0);
	assign stat.is_fill    = (cmd_q == CMD_FILL);
	assign stat.pix_ok     = pix_ok_q;
	assign stat.col_last   = (i_q + 13'd1 == x_end);
	assign stat.row_last   = (j_q + 12'd1 == y_end);
	assign stat.out_free   = !out_valid_q || !out_stall;

endmodule

### src/abpw_ctrl.sv
// Controller of the alpha blend pixel writer: one-hot sequencer that walks a check
// step per command, then address, read and write steps per pixel. Depends on abpw_pkg.
module abpw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  abpw_pkg::dp_stat_t  stat,
	output abpw_pkg::ctrl_cmd_t cmd
);
	import abpw_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_CHECK = 7'b0000010,
		S_ADDR  = 7'b0000100,
		S_READ  = 7'b0001000,
		S_WRITE = 7'b0010000,
		S_NEXT  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (stat.pre_err || stat.fill_empty)
					state_d = S_DONE;
				else
					state_d = S_ADDR;
			end
			S_ADDR: begin
				cmd.addr = 1'b1;
				state_d  = S_READ;
			end
			S_READ: begin
				if (stat.pix_ok) begin
					cmd.mem_rd = 1'b1;
					state_d    = S_WRITE;
				end else if (stat.is_fill) begin
					state_d = S_NEXT;   // clipped pixel, skip
				end else begin
					cmd.set_bound = 1'b1;
					state_d       = S_DONE;
				end
			end
			S_WRITE: begin
				cmd.mem_wr = 1'b1;
				state_d    = stat.is_fill ? S_NEXT : S_DONE;
			end
			S_NEXT: begin
				if (!stat.col_last) begin
					cmd.step_col = 1'b1;
					state_d      = S_ADDR;
				end else if (!stat.row_last) begin
					cmd.step_row = 1'b1;
					state_d      = S_ADDR;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

### src/alpha_blend_pixel_writer.sv
// Alpha blend pixel writer: a read or draw steps through check, address, read, write
// (no write when out of bound), a rejected command or empty fill through check only,
// a fill through check, then address, read, write, next per pixel (no write for a
// pixel clipped by the store limits). One command at a time; the next beat is taken
// the cycle after the result is loaded, even while that result waits in the output register.
// Reset clears sequencer, output valid and config registers, not the frame store.
module alpha_blend_pixel_writer #(
	parameter int unsigned MAX_WIDTH    = abpw_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT   = abpw_pkg::MAX_HEIGHT_DEF,
	parameter int unsigned STORE_PIXELS = abpw_pkg::STORE_PIXELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  abpw_pkg::in_beat_t           in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output abpw_pkg::out_beat_t          out_data,
	input  logic                         cfg_we,
	input  logic [abpw_pkg::CFG_IW-1:0]  cfg_index,
	input  logic [abpw_pkg::CFG_DW-1:0]  cfg_data
);
	import abpw_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequencer: one state per step of the per-pixel read-modify-write
	abpw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: config, frame store, blend, fill counters, result register
	abpw_dp #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_HEIGHT   (MAX_HEIGHT),
		.STORE_PIXELS (STORE_PIXELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

### src/abpw_checker.sv
// Port-level checks for the alpha blend pixel writer, bound to the top level.
// Depends on abpw_pkg and alpha_blend_pixel_writer.
module abpw_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input abpw_pkg::out_beat_t          out_data
);
	import abpw_pkg::*;

	// one command in flight: an accepted beat closes the input
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a command is in flight");

	// failed commands return no pixel data
	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |->
			out_data.read_alpha == 8'h00 && out_data.read_red == 8'h00
			&& out_data.read_green == 8'h00 && out_data.read_blue == 8'h00)
		else $error("error result carries pixel data");

	// read alpha is either opaque on a good read or zero
	a_alpha_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.read_alpha != 8'h00 |->
			out_data.read_alpha == ALPHA_OPAQUE && out_data.status == ST_OK)
		else $error("bad read alpha");

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

endmodule

bind alpha_blend_pixel_writer abpw_checker u_abpw_checker (.*);
